// ===== sv/lfu_pkg.sv =====
// shared constants and control/status types for the lfu lookup-replace unit
// no dependencies
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CAP_W          = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // register index of capacity_limit
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic start;   // latch request, clear scan trackers
    logic scan;    // walk lines looking for match, victim, free slot
    logic decide;  // pick target line, rewind the line counter
    logic rank;    // walk lines updating recency ranks
    logic commit;  // write line, drive result
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rank_done;
    logic need_rank;
  } lfu_sts_t;

endpackage

// ===== sv/lfu_ctrl.sv =====
// request sequencer for the lfu lookup-replace unit
// uses lfu_pkg command and status types
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lfu_sts_t sts,
  output lfu_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_RANK   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = sts.need_rank ? S_RANK : S_COMMIT;
      S_RANK:   if (sts.rank_done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.start  = (state_r == S_IDLE) && start;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.decide = (state_r == S_DECIDE);
  assign cmd.rank   = (state_r == S_RANK);
  assign cmd.commit = (state_r == S_COMMIT);

endmodule

// ===== sv/lfu_dp.sv =====
// line storage, scan trackers and rank update datapath
// uses lfu_pkg; driven by lfu_ctrl commands
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lfu_cmd_t         cmd,
  output lfu_sts_t         sts,
  input  logic [CAP_W-1:0] cap,
  input  logic             in_operation,
  input  logic [KEY_W-1:0] in_lookup_key,
  input  logic [VAL_W-1:0] in_store_value,
  output logic             out_valid,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // line memories
  logic [KEY_W-1:0]      key_mem   [ENTRIES];
  logic [VAL_W-1:0]      data_mem  [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [IDX_W-1:0]      rank_mem  [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [OCC_W-1:0]      occ_r;

  // request
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // walk counter and read pipeline
  logic [CNT_W-1:0] cnt_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [KEY_W-1:0]      rd_key_r;
  logic [VAL_W-1:0]      rd_data_r;
  logic [COUNT_BITS-1:0] rd_count_r;
  logic [IDX_W-1:0]      rd_rank_r;

  // scan trackers
  logic                  hit_r, vic_r, free_r;
  logic [IDX_W-1:0]      hit_idx_r, vic_idx_r, free_idx_r;
  logic [VAL_W-1:0]      hit_data_r;
  logic [COUNT_BITS-1:0] hit_count_r, vic_count_r;
  logic [IDX_W-1:0]      hit_rank_r, vic_rank_r;

  // decision
  logic                  all_r, inc_occ_r;
  logic [IDX_W-1:0]      tgt_r, thr_r;
  logic [COUNT_BITS-1:0] new_count_r;

  logic             walk, cnt_live, rd_valid_line, is_match;
  logic [IDX_W-1:0] raddr;
  logic [CMP_W-1:0] eff_cap, cap_ext;
  logic             full, cap_zero, do_put;
  logic             rank_we;
  logic [IDX_W-1:0] rank_wdata;

  assign walk     = cmd.scan || cmd.rank;
  assign cnt_live = (cnt_r < CNT_W'(ENTRIES));
  assign raddr    = cnt_r[IDX_W-1:0];
  assign rd_valid_line = valid_r[rd_idx_r];
  assign is_match = rd_valid_line && (rd_key_r == key_r);

  assign cap_ext  = CMP_W'(cap);
  assign eff_cap  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign full     = (CMP_W'(occ_r) >= eff_cap);
  assign cap_zero = (cap == '0);
  assign do_put   = (op_r == OP_PUT) && !cap_zero;

  assign sts.scan_done = cmd.scan && !cnt_live && !rd_v_r;
  assign sts.rank_done = cmd.rank && !cnt_live && !rd_v_r;
  assign sts.need_rank = ((op_r == OP_GET) && hit_r) || do_put;

  // recency: target to rank 0, lines below thr (or all) age by one
  always_comb begin
    rank_we    = 1'b0;
    rank_wdata = rd_rank_r + IDX_W'(1);
    if (cmd.rank && rd_v_r) begin
      if (rd_idx_r == tgt_r) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
      end else if (rd_valid_line && (all_r || (rd_rank_r < thr_r))) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[raddr];
    rd_data_r  <= data_mem[raddr];
    rd_count_r <= count_mem[raddr];
    rd_rank_r  <= rank_mem[raddr];
    if (rank_we) rank_mem[rd_idx_r] <= rank_wdata;
    if (cmd.commit && (do_put || ((op_r == OP_GET) && hit_r)))
      count_mem[tgt_r] <= new_count_r;
    if (cmd.commit && do_put) begin
      data_mem[tgt_r] <= val_r;
      if (!hit_r) key_mem[tgt_r] <= key_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      occ_r     <= '0;
      cnt_r     <= '0;
      rd_v_r    <= 1'b0;
      hit_r     <= 1'b0;
      vic_r     <= 1'b0;
      free_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v_r    <= walk && cnt_live;
      out_valid <= cmd.commit && (op_r == OP_GET);
      if (walk && cnt_live) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.start || cmd.decide) cnt_r <= '0;
      if (cmd.start) begin
        hit_r  <= 1'b0;
        vic_r  <= 1'b0;
        free_r <= 1'b0;
      end
      if (cmd.scan && rd_v_r) begin
        if (is_match && !hit_r) hit_r <= 1'b1;
        if (!rd_valid_line && !free_r) free_r <= 1'b1;
        if (rd_valid_line) vic_r <= 1'b1;
      end
      if (cmd.commit && do_put && !hit_r) begin
        valid_r[tgt_r] <= 1'b1;
        if (inc_occ_r) occ_r <= occ_r + OCC_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (walk && cnt_live) rd_idx_r <= raddr;
    if (cmd.start) begin
      op_r  <= in_operation;
      key_r <= in_lookup_key;
      val_r <= in_store_value;
    end
    if (cmd.scan && rd_v_r) begin
      if (is_match && !hit_r) begin
        hit_idx_r   <= rd_idx_r;
        hit_data_r  <= rd_data_r;
        hit_count_r <= rd_count_r;
        hit_rank_r  <= rd_rank_r;
      end
      if (!rd_valid_line && !free_r) free_idx_r <= rd_idx_r;
      // lowest count wins, older line on a tie
      if (rd_valid_line && (!vic_r || (rd_count_r < vic_count_r) ||
          ((rd_count_r == vic_count_r) && (rd_rank_r > vic_rank_r)))) begin
        vic_idx_r   <= rd_idx_r;
        vic_count_r <= rd_count_r;
        vic_rank_r  <= rd_rank_r;
      end
    end
    if (cmd.decide) begin
      all_r     <= 1'b0;
      inc_occ_r <= 1'b0;
      priority if (hit_r) begin
        tgt_r       <= hit_idx_r;
        thr_r       <= hit_rank_r;
        new_count_r <= (hit_count_r < COUNT_MAX) ? hit_count_r + COUNT_ONE : hit_count_r;
      end else if (full) begin
        // evicted line is reused in place, younger lines age by one
        tgt_r       <= vic_idx_r;
        thr_r       <= vic_rank_r;
        new_count_r <= COUNT_ONE;
      end else begin
        tgt_r       <= free_idx_r;
        thr_r       <= '0;
        all_r       <= 1'b1;
        inc_occ_r   <= 1'b1;
        new_count_r <= COUNT_ONE;
      end
    end
    if (cmd.commit) begin
      out_hit        <= hit_r;
      out_read_value <= hit_r ? hit_data_r : '0;
    end
  end

endmodule

// ===== sv/lfu_cache_lookup_replace_unit.sv =====
// top level of the lfu lookup-replace unit: config register, sequencer, datapath
// depends on lfu_pkg, lfu_ctrl, lfu_dp
//
// channel   direction  handshake                 payload
// in        input      start high, busy low      in_operation, in_lookup_key, in_store_value
// out       output     out_valid, one cycle      out_hit, out_read_value (gets only)
// cfg       input      psel/penable/pwrite       capacity_limit at address 0
//
// a request walks every line once to find its key, the eviction victim and a
// free line, reading one line at a time through a registered read, takes a
// decide step, then walks the lines again to update recency ranks and then
// commits; busy covers the whole request, so a new request is only taken
// once the last one has committed; a get miss or a put at capacity zero skips the rank walk
// the single read port of the line memories makes each walk go line by line
// busy stays high from accept until commit; the result strobe is registered
// from the commit, appears in the cycle after it and cannot be held off;
// synchronous reset clears all valid marks
module lfu_cache_lookup_replace_unit
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_operation,
  input  logic [KEY_W-1:0] in_lookup_key,
  input  logic [VAL_W-1:0] in_store_value,
  output logic             out_valid,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CAP_W-1:0] cap_r;
  logic             reg_sel;
  lfu_cmd_t         cmd;
  lfu_sts_t         sts;

  // register index is the word address
  assign reg_sel = (paddr[2] == REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cap            (cap_r),
    .in_operation   (in_operation),
    .in_lookup_key  (in_lookup_key),
    .in_store_value (in_store_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

`ifndef SYNTHESIS
  // a result only follows a request in flight
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");
  // results never come back to back
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result");
  // an accepted request makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request dropped");
  // a miss never carries data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_read_value == '0)) else $error("miss data");
`endif

endmodule

// ===== test/tb_lfu_cache_lookup_replace_unit.sv =====
// self-checking testbench for the lfu lookup-replace unit
// depends on lfu_pkg and lfu_cache_lookup_replace_unit; a scoreboard class predicts get responses
module tb_lfu_cache_lookup_replace_unit;
  import lfu_pkg::*;

  localparam int LINES   = ENTRIES_DEF;
  localparam int CNT_W   = COUNT_BITS_DEF;
  localparam int SETTLE  = 2 * LINES + 10;   // a put yields no response, let it finish

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_resp_t;

  // lfu store predictor plus queue of expected get responses
  class lfu_scoreboard;
    bit             line_ok   [LINES];
    bit [KEY_W-1:0] line_tag  [LINES];
    bit [VAL_W-1:0] line_word [LINES];
    bit [CNT_W-1:0] line_uses [LINES];
    int             line_age  [LINES];
    int             held;
    bit [CAP_W-1:0] cap;
    lookup_resp_t   pending_resp[$];
    int             errors;

    function new();
      foreach (line_ok[i]) line_ok[i] = 0;
      held   = 0;
      cap    = CAP_RESET;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // bump use count (saturating) and make line s the most recent
    function void refresh(int s);
      int r;
      r = line_age[s];
      if (line_uses[s] != {CNT_W{1'b1}}) line_uses[s]++;
      for (int j = 0; j < LINES; j++)
        if (line_ok[j] && line_age[j] < r) line_age[j]++;
      line_age[s] = 0;
    endfunction

    function int pick_victim();
      int v;
      v = -1;
      for (int j = 0; j < LINES; j++) begin
        if (!line_ok[j]) continue;
        if (v < 0 || line_uses[j] < line_uses[v] ||
            (line_uses[j] == line_uses[v] && line_age[j] > line_age[v]))
          v = j;
      end
      if (v < 0) return -1;
      for (int j = 0; j < LINES; j++)
        if (line_ok[j] && line_age[j] > line_age[v]) line_age[j]--;
      line_ok[v] = 0;
      if (held > 0) held--;
      return v;
    endfunction

    // accepted request: update the model, queue a response for gets
    function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int eff, s;
      lookup_resp_t r;
      eff = (cap > LINES) ? LINES : cap;
      s = -1;
      for (int i = 0; i < LINES; i++)
        if (s < 0 && line_ok[i] && line_tag[i] == key) s = i;
      if (op == OP_GET) begin
        if (s >= 0) begin
          refresh(s);
          r.hit = 1'b1;
          r.value = line_word[s];
        end else begin
          r.hit = 1'b0;
          r.value = '0;
        end
        pending_resp.push_back(r);
        return;
      end
      if (eff == 0) return;
      if (s >= 0) begin
        line_word[s] = val;
        refresh(s);
        return;
      end
      if (held >= eff) s = pick_victim();
      else begin
        for (int i = 0; i < LINES; i++)
          if (s < 0 && !line_ok[i]) s = i;
      end
      if (s < 0) return;
      for (int j = 0; j < LINES; j++)
        if (line_ok[j]) line_age[j]++;
      line_ok[s]   = 1;
      line_tag[s]  = key;
      line_word[s] = val;
      line_uses[s] = 1;
      line_age[s]  = 0;
      held++;
    endfunction

    function void check_response(logic hit, logic [VAL_W-1:0] value);
      lookup_resp_t e;
      if (pending_resp.size() == 0) begin
        report($sformatf("unexpected response hit=%0b value=%h", hit, value));
        return;
      end
      e = pending_resp.pop_front();
      if (hit !== e.hit)
        report($sformatf("hit got %0b want %0b", hit, e.hit));
      if (value !== e.value)
        report($sformatf("read_value got %h want %h", value, e.value));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_operation;
  logic [KEY_W-1:0] in_lookup_key;
  logic [VAL_W-1:0] in_store_value;
  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             psel, penable, pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  lfu_scoreboard sb = new();
  int            idle_pct;
  logic [KEY_W-1:0] key_pool [24];

  lfu_cache_lookup_replace_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_lookup_key(in_lookup_key),
    .in_store_value(in_store_value), .out_valid(out_valid), .out_hit(out_hit),
    .out_read_value(out_read_value), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // sample at the edge: pre-update values of start/busy and the response strobe
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_operation, in_lookup_key, in_store_value);
      if (out_valid) sb.check_response(out_hit, out_read_value);
    end
  end

  // drive one request, hold it until the edge where busy is low
  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_lookup_key  <= key;
    in_store_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending, wait for every response and any trailing put
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_resp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // two-phase write of the capacity register, block is idle
  task automatic write_capacity(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {2'b00, REG_CAPACITY};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.cap  = v[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom();
    return key_pool[$urandom_range(23)];
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      // one mid-phase pause until all responses are in
      if (i == n / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_resp.size() != 0) @(posedge clk);
      end
      send_request($urandom_range(1) ? OP_PUT : OP_GET, pick_key(), $urandom());
    end
    drain();
  endtask

  initial begin
    int caps [8];
    rst_n = 1'b0;  start = 1'b0;  in_operation = OP_GET;
    in_lookup_key = '0;  in_store_value = '0;
    psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
    idle_pct = 0;
    foreach (key_pool[i]) key_pool[i] = (i < 2) ? (i == 0 ? '0 : '1) : $urandom();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, overwrite, eviction on full store
    write_capacity(16);
    send_request(OP_GET, 32'h0, 32'h0);              // miss on empty store
    send_request(OP_PUT, 32'h0, 32'h0);
    send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'h0, 32'hffff_ffff);
    send_request(OP_GET, 32'hffff_ffff, 32'h0);
    send_request(OP_PUT, 32'h0, 32'ha5a5_5a5a);      // overwrite present key
    send_request(OP_GET, 32'h0, 32'h0);
    for (int k = 1; k <= 15; k++) send_request(OP_PUT, k, k * 32'h1111);
    send_request(OP_PUT, 32'h100, 32'h1234_5678);    // full: evicts lowest count
    send_request(OP_GET, 32'h1, 32'h0);
    send_request(OP_GET, 32'h100, 32'h0);
    drain();
    // capacity zero: puts ignored, gets still search
    write_capacity(0);
    send_request(OP_PUT, 32'h200, 32'h1);
    send_request(OP_GET, 32'h200, 32'h0);
    send_request(OP_GET, 32'h100, 32'h0);
    drain();
    // capacity above line count saturates; then lowered below occupancy
    write_capacity(31);
    send_request(OP_PUT, 32'h300, 32'h3);
    send_request(OP_GET, 32'h300, 32'h0);
    drain();
    write_capacity(2);
    send_request(OP_PUT, 32'h400, 32'h4);
    send_request(OP_GET, 32'h400, 32'h0);
    send_request(OP_GET, 32'h300, 32'h0);
    drain();

    caps = '{16, 4, 1, 31, 8, 0, 3, 16};
    for (int p = 0; p < 8; p++) begin
      idle_pct = (p < 3) ? 20 : (p < 6) ? 50 : 0;
      write_capacity(caps[p]);
      random_phase(215);
    end

    if (sb.pending_resp.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending_resp.size()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
